// ----- rtl/mpe_pkg.sv -----
// shared types, constants and tables for the pose-to-euler-and-velocity block
package mpe_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int CIT_W = $clog2(CORDIC_ITERATIONS + 1);
    localparam int ATAN_IDX_W = 5;

    localparam int TERM_W = 34;
    localparam int ANGLE_W = 16;
    localparam int NUM_W = 52;
    localparam int DEN_W = 48;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic signed [TERM_W-1:0] ONE_Q28 = 34'sd268435456;
    localparam logic signed [TERM_W-1:0] PI_Q29 = 34'sd1686629713;
    localparam logic [19:0] MIN_INTERVAL_RESET = 20'd8000;
    localparam logic [19:0] MIN_INTERVAL_ONE = 20'd1;
    localparam logic signed [29:0] USEC_PER_SEC = 30'sd1000000;

    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd421657428, 30'd248918915, 30'd131521918, 30'd66762579, 30'd33510843,
        30'd16771758, 30'd8387925, 30'd4194219, 30'd2097141, 30'd1048575,
        30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768, 30'd16384,
        30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256, 30'd128,
        30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0, 30'd0
    };

    typedef struct packed {
        logic [47:0]        timestamp_us;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } mpe_in_t;

    typedef struct packed {
        logic [47:0]        rel_time_us;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } mpe_out_t;

endpackage

// ----- rtl/mpe_cordic.sv -----
// iterative vectoring cordic, one micro-rotation per cycle, angle out in q3.13
module mpe_cordic
    import mpe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [TERM_W-1:0] y_in,
    input  logic signed [TERM_W-1:0] x_in,
    output logic                     done,
    output logic signed [ANGLE_W-1:0] angle
);

    localparam int CW = 38;
    localparam int ZW = 34;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CIT_W-1:0]      it_reg;
    logic signed [CW-1:0]  x_reg;
    logic signed [CW-1:0]  y_reg;
    logic signed [ZW-1:0]  z_reg;
    logic signed [CW-1:0]  x_in_e;
    logic signed [CW-1:0]  y_in_e;
    logic signed [CW-1:0]  dx;
    logic signed [CW-1:0]  dy;
    logic [ATAN_IDX_W-1:0] sh;
    logic signed [ZW-1:0]  tab;
    logic signed [ZW:0]    z_round;
    logic signed [ZW-16:0] z_q;

    always_comb
    begin
        x_in_e = CW'(x_in);
        y_in_e = CW'(y_in);
        sh = ATAN_IDX_W'(it_reg);
        dx = x_reg >>> sh;
        dy = y_reg >>> sh;
        tab = $signed({4'b0, ATAN_TAB[sh]});
        z_round = (ZW+1)'(z_reg) + 35'sd32768;
        z_q = z_round[ZW:16];
        if (z_q > 19'sd32767)
        begin
            angle = 16'sh7fff;
        end
        else if (z_q < -19'sd32768)
        begin
            angle = 16'sh8000;
        end
        else
        begin
            angle = z_q[15:0];
        end
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            done_reg <= start ? (x_in == '0 && y_in == '0)
                              : (busy_reg && it_reg == CIT_W'(CORDIC_ITERATIONS - 1));
            if (start)
            begin
                it_reg   <= '0;
                busy_reg <= !(x_in == '0 && y_in == '0);
            end
            else if (busy_reg)
            begin
                it_reg <= it_reg + 1'b1;
                if (it_reg == CIT_W'(CORDIC_ITERATIONS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (x_in < 0)
            begin
                x_reg <= -x_in_e;
                y_reg <= -y_in_e;
                z_reg <= (y_in >= 0) ? PI_Q29 : -PI_Q29;
            end
            else
            begin
                x_reg <= x_in_e;
                y_reg <= y_in_e;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + dy;
                y_reg <= y_reg - dx;
                z_reg <= z_reg + tab;
            end
            else
            begin
                x_reg <= x_reg - dy;
                y_reg <= y_reg + dx;
                z_reg <= z_reg - tab;
            end
        end
    end

endmodule

// ----- rtl/mpe_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module mpe_div
    import mpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [DEN_W:0]       trial;
    logic                 fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        fits = (trial >= {1'b0, den_reg});
    end

    assign done = done_reg;
    assign quo = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == DIV_CNT_W'(NUM_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DEN_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[DEN_W-1:0];
            end
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

endmodule

// ----- rtl/mocap_pose_to_euler_and_velocity_top.sv -----
// pose sample to relative time, zyx euler angles and finite-difference velocity
//
// pose channel (pose_valid/pose_ready/pose) takes one sample; result channel
// (result_valid/result_ready/result) gives one item per sample, in order.
// cfg channel (cfg_valid/cfg_ready/cfg_data) writes min_interval_us; cfg_ready
// is always high, write it only while no sample is in flight.
// one sample goes from acceptance to result through quaternion products on the
// shared multiplier, the setup states S_TERMS, S_SSQ and S_SQLD, 29 square-root
// steps, three cordic runs of CORDIC_ITERATIONS micro-rotations (none for a zero
// vector), three divides (52 quotient bits plus setup, one per velocity axis)
// and the output state. pose_ready is high only while the sequencer is idle, so
// a new sample is taken only after the last one has reached the output register.
// a finished result sits in the output register; a new sample may be taken
// while it waits, and if the receiver still stalls when the next result is
// done, the sequencer holds until the register frees.
// reset clears the first-sample flag, start time, previous time and position,
// and sets min_interval_us to 8000.
module mocap_pose_to_euler_and_velocity_top
    import mpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pose_valid,
    output logic        pose_ready,
    input  mpe_in_t     pose,
    output logic        result_valid,
    input  logic        result_ready,
    output mpe_out_t    result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_QMUL  = 4'd1;
    localparam logic [3:0] S_TERMS = 4'd2;
    localparam logic [3:0] S_SSQ   = 4'd3;
    localparam logic [3:0] S_SQLD  = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_ROLL  = 4'd6;
    localparam logic [3:0] S_PITCH = 4'd7;
    localparam logic [3:0] S_YAW   = 4'd8;
    localparam logic [3:0] S_VMUL  = 4'd9;
    localparam logic [3:0] S_VLD   = 4'd10;
    localparam logic [3:0] S_VDIV  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]  state_reg;
    logic [3:0]  mstep_reg;
    logic        seen_reg;
    logic [47:0] start_reg;
    logic [47:0] prev_rel_reg;
    logic [47:0] rel_reg;
    logic [19:0] min_int_reg;
    logic [4:0]  sq_cnt_reg;
    logic        cstart_reg;
    logic [1:0]  vax_reg;
    logic        result_valid_reg;
    logic [31:0] prev_pos_reg [3];

    logic signed [32:0] dpos_reg [3];
    logic signed [15:0] qw_reg;
    logic signed [15:0] qx_reg;
    logic signed [15:0] qy_reg;
    logic signed [15:0] qz_reg;
    logic signed [62:0] p_reg;
    logic signed [32:0] sacc_reg;
    logic signed [32:0] t2acc_reg;
    logic signed [32:0] t3acc_reg;
    logic signed [32:0] t4acc_reg;
    logic signed [32:0] t5acc_reg;
    logic signed [29:0] s_reg;
    logic signed [TERM_W-1:0] t2_reg;
    logic signed [TERM_W-1:0] t3_reg;
    logic signed [TERM_W-1:0] t4_reg;
    logic signed [TERM_W-1:0] t5_reg;
    logic [DEN_W-1:0]   dt_reg;
    logic [57:0]        sq_in_reg;
    logic [30:0]        sq_rem_reg;
    logic [28:0]        sq_root_reg;
    logic signed [15:0] roll_reg;
    logic signed [15:0] pitch_reg;
    logic signed [15:0] yaw_reg;
    logic               vsign_reg;
    logic signed [31:0] vel_reg [3];
    mpe_out_t           result_reg;

    logic               accept;
    logic               out_free;
    logic signed [32:0] mul_a;
    logic signed [29:0] mul_b;
    logic signed [62:0] p_next;
    logic signed [32:0] p33;
    logic signed [TERM_W-1:0] s2;
    logic signed [48:0] dt_diff;
    logic [19:0]        floor_dt;
    logic [32:0]        sq_rem_t;
    logic [32:0]        sq_trial;
    logic               sq_fit;
    logic signed [TERM_W-1:0] cy;
    logic signed [TERM_W-1:0] cx;
    logic               cdone;
    logic signed [15:0] cangle;
    logic signed [52:0] pn;
    logic [52:0]        pmag;
    logic               dstart;
    logic               ddone;
    logic [NUM_W-1:0]   dquo;
    logic signed [31:0] vel_sat;

    assign accept = pose_valid && pose_ready;
    assign pose_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign result_valid = result_valid_reg;
    assign result = result_reg;
    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_QMUL:
            begin
                case (mstep_reg)
                    4'd0:    begin mul_a = 33'(qw_reg); mul_b = 30'(qy_reg); end
                    4'd1:    begin mul_a = 33'(qx_reg); mul_b = 30'(qz_reg); end
                    4'd2:    begin mul_a = 33'(qw_reg); mul_b = 30'(qx_reg); end
                    4'd3:    begin mul_a = 33'(qy_reg); mul_b = 30'(qz_reg); end
                    4'd4:    begin mul_a = 33'(qx_reg); mul_b = 30'(qx_reg); end
                    4'd5:    begin mul_a = 33'(qy_reg); mul_b = 30'(qy_reg); end
                    4'd6:    begin mul_a = 33'(qx_reg); mul_b = 30'(qy_reg); end
                    4'd7:    begin mul_a = 33'(qw_reg); mul_b = 30'(qz_reg); end
                    4'd8:    begin mul_a = 33'(qz_reg); mul_b = 30'(qz_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_SSQ:
            begin
                mul_a = 33'(s_reg);
                mul_b = s_reg;
            end
            S_VMUL:
            begin
                mul_a = dpos_reg[vax_reg];
                mul_b = USEC_PER_SEC;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        p_next = mul_a * mul_b;
        p33 = p_reg[32:0];
    end

    always_comb
    begin
        s2 = {sacc_reg, 1'b0};
        floor_dt = (min_int_reg == '0) ? MIN_INTERVAL_ONE : min_int_reg;
        dt_diff = $signed({1'b0, rel_reg}) - $signed({1'b0, prev_rel_reg});
        sq_rem_t = {sq_rem_reg, sq_in_reg[57:56]};
        sq_trial = {2'b00, sq_root_reg, 2'b01};
        sq_fit = (sq_rem_t >= sq_trial);
        pn = p_reg[52:0];
        pmag = (pn < 0) ? 53'(-pn) : 53'(pn);
        dstart = (state_reg == S_VLD);
        if (vsign_reg)
        begin
            vel_sat = (dquo > 52'd2147483648) ? 32'sh80000000 : 32'(-dquo[31:0]);
        end
        else
        begin
            vel_sat = (dquo > 52'd2147483647) ? 32'sh7fffffff : $signed(dquo[31:0]);
        end
        case (state_reg)
            S_PITCH:
            begin
                cy = TERM_W'(s_reg);
                cx = TERM_W'($signed({1'b0, sq_root_reg}));
            end
            S_YAW:
            begin
                cy = t4_reg;
                cx = t5_reg;
            end
            default:
            begin
                cy = t2_reg;
                cx = t3_reg;
            end
        endcase
    end

    mpe_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cstart_reg),
        .y_in  (cy),
        .x_in  (cx),
        .done  (cdone),
        .angle (cangle)
    );

    mpe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .num   (pmag[NUM_W-1:0]),
        .den   (dt_reg),
        .done  (ddone),
        .quo   (dquo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            mstep_reg        <= '0;
            seen_reg         <= 1'b0;
            start_reg        <= '0;
            prev_rel_reg     <= '0;
            min_int_reg      <= MIN_INTERVAL_RESET;
            sq_cnt_reg       <= '0;
            cstart_reg       <= 1'b0;
            vax_reg          <= '0;
            result_valid_reg <= 1'b0;
            prev_pos_reg[0]  <= '0;
            prev_pos_reg[1]  <= '0;
            prev_pos_reg[2]  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                min_int_reg <= cfg_data;
            end
            if ((state_reg == S_OUT) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            cstart_reg <= ((state_reg == S_SQRT) && (sq_cnt_reg == 5'd28))
                          || (((state_reg == S_ROLL) || (state_reg == S_PITCH)) && cdone);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        seen_reg <= 1'b1;
                        if (!seen_reg)
                        begin
                            start_reg <= pose.timestamp_us;
                        end
                        prev_pos_reg[0] <= pose.pos_x;
                        prev_pos_reg[1] <= pose.pos_y;
                        prev_pos_reg[2] <= pose.pos_z;
                        mstep_reg <= '0;
                        state_reg <= S_QMUL;
                    end
                end
                S_QMUL:
                begin
                    mstep_reg <= mstep_reg + 1'b1;
                    if (mstep_reg == 4'd9)
                    begin
                        state_reg <= S_TERMS;
                    end
                end
                S_TERMS: state_reg <= S_SSQ;
                S_SSQ:   state_reg <= S_SQLD;
                S_SQLD:
                begin
                    sq_cnt_reg <= '0;
                    state_reg  <= S_SQRT;
                end
                S_SQRT:
                begin
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == 5'd28)
                    begin
                        state_reg  <= S_ROLL;
                    end
                end
                S_ROLL:
                begin
                    if (cdone)
                    begin
                        state_reg  <= S_PITCH;
                    end
                end
                S_PITCH:
                begin
                    if (cdone)
                    begin
                        state_reg  <= S_YAW;
                    end
                end
                S_YAW:
                begin
                    if (cdone)
                    begin
                        vax_reg   <= '0;
                        state_reg <= S_VMUL;
                    end
                end
                S_VMUL: state_reg <= S_VLD;
                S_VLD:  state_reg <= S_VDIV;
                S_VDIV:
                begin
                    if (ddone)
                    begin
                        if (vax_reg == 2'd2)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            vax_reg   <= vax_reg + 1'b1;
                            state_reg <= S_VMUL;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        prev_rel_reg     <= rel_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        if (accept)
        begin
            rel_reg <= seen_reg ? (pose.timestamp_us - start_reg) : '0;
            qw_reg <= pose.quat_w;
            qx_reg <= pose.quat_x;
            qy_reg <= pose.quat_y;
            qz_reg <= pose.quat_z;
            dpos_reg[0] <= 33'(pose.pos_x) - 33'($signed(prev_pos_reg[0]));
            dpos_reg[1] <= 33'(pose.pos_y) - 33'($signed(prev_pos_reg[1]));
            dpos_reg[2] <= 33'(pose.pos_z) - 33'($signed(prev_pos_reg[2]));
        end
        if (state_reg == S_QMUL)
        begin
            case (mstep_reg)
                4'd1: sacc_reg <= p33;
                4'd2: sacc_reg <= sacc_reg - p33;
                4'd3: t2acc_reg <= p33;
                4'd4: t2acc_reg <= t2acc_reg + p33;
                4'd5: t3acc_reg <= p33;
                4'd6:
                begin
                    t3acc_reg <= t3acc_reg + p33;
                    t5acc_reg <= p33;
                end
                4'd7: t4acc_reg <= p33;
                4'd8: t4acc_reg <= t4acc_reg + p33;
                4'd9: t5acc_reg <= t5acc_reg + p33;
                default: sacc_reg <= sacc_reg;
            endcase
        end
        if (state_reg == S_TERMS)
        begin
            if (s2 > ONE_Q28)
            begin
                s_reg <= 30'(ONE_Q28);
            end
            else if (s2 < -ONE_Q28)
            begin
                s_reg <= 30'(-ONE_Q28);
            end
            else
            begin
                s_reg <= 30'(s2);
            end
            t2_reg <= {t2acc_reg, 1'b0};
            t3_reg <= ONE_Q28 - {t3acc_reg, 1'b0};
            t4_reg <= {t4acc_reg, 1'b0};
            t5_reg <= ONE_Q28 - {t5acc_reg, 1'b0};
            if (dt_diff < $signed({29'b0, floor_dt}))
            begin
                dt_reg <= DEN_W'(floor_dt);
            end
            else
            begin
                dt_reg <= dt_diff[DEN_W-1:0];
            end
        end
        if (state_reg == S_SQLD)
        begin
            sq_in_reg   <= {1'b0, 57'(57'h100000000000000 - p_reg[56:0])};
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        if (state_reg == S_SQRT)
        begin
            sq_in_reg <= {sq_in_reg[55:0], 2'b00};
            if (sq_fit)
            begin
                sq_rem_reg  <= 31'(sq_rem_t - sq_trial);
                sq_root_reg <= {sq_root_reg[27:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= sq_rem_t[30:0];
                sq_root_reg <= {sq_root_reg[27:0], 1'b0};
            end
        end
        if (cdone)
        begin
            case (state_reg)
                S_ROLL:  roll_reg <= cangle;
                S_PITCH: pitch_reg <= cangle;
                default: yaw_reg <= cangle;
            endcase
        end
        if (state_reg == S_VLD)
        begin
            vsign_reg <= (pn < 0);
        end
        if (state_reg == S_VDIV && ddone)
        begin
            vel_reg[vax_reg] <= vel_sat;
        end
        if (state_reg == S_OUT && out_free)
        begin
            result_reg.rel_time_us <= rel_reg;
            result_reg.roll        <= roll_reg;
            result_reg.pitch       <= pitch_reg;
            result_reg.yaw         <= yaw_reg;
            result_reg.vel_x       <= vel_reg[0];
            result_reg.vel_y       <= vel_reg[1];
            result_reg.vel_z       <= vel_reg[2];
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_QMUL && !pose_ready))
        else $error("sample accepted but sequencer did not start");

    a_cordic_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        cdone |-> (state_reg == S_ROLL || state_reg == S_PITCH || state_reg == S_YAW))
        else $error("cordic finished outside an angle state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        ddone |-> (state_reg == S_VDIV))
        else $error("divider finished outside the divide state");
`endif

endmodule
